@@ hw/rtl/tah_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traffic automaton package
// Shared widths, cell and command codes, and the control structures that the
// top level hands to every row cell.
// ----------------------------------------------------------------------------
package tah_pkg;

  // Default grid bounds for the top-level parameters.
  localparam int DefMaxRows = 64;
  localparam int DefMaxCols = 64;

  // Field widths of the channels.
  localparam int CmdW      = 2;
  localparam int RowFieldW = 6;
  localparam int ColFieldW = 6;
  localparam int CellW     = 2;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 7;

  typedef logic [CellW-1:0] cell_t;

  // Cell contents.
  localparam cell_t CellEmpty = 2'd0;
  localparam cell_t CellBlue  = 2'd1;
  localparam cell_t CellRed   = 2'd2;
  localparam cell_t CellBad   = 2'd3;

  // Command codes.
  localparam logic [CmdW-1:0] CmdLoad = 2'd0;
  localparam logic [CmdW-1:0] CmdStep = 2'd1;
  localparam logic [CmdW-1:0] CmdRead = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegRowsInUse = 1'b0;
  localparam logic [CfgIdxW-1:0] RegColsInUse = 1'b1;

  // Size register reset value and lower clamp.
  localparam logic [CfgDataW-1:0] SizeReset = 7'd64;
  localparam logic [CfgDataW-1:0] SizeMin   = 7'd2;

  // Column-level control broadcast to every row cell.
  typedef struct packed {
    logic  clear;      // start of a command: clear the result chain
    logic  shift;      // rotate the row by one column
    logic  proc;       // the head column is being processed
    logic  step_en;    // command is a half step
    logic  blue;       // half step moves blue cars
    logic  load_en;    // command is a valid load
    cell_t load_val;
    logic  read_en;    // command is a read
    logic  col_in;     // head column lies inside the columns in use
    logic  col_hit;    // head column equals the requested column
    logic  col_last;   // head column is the last column in use
    logic  col0_pass;  // final in-place pass over column 0
    logic  cap_s0;     // capture original column 0
    logic  cap_s1;     // capture original column 1
  } row_ctrl_t;

  // Row-level selection for one cell.
  typedef struct packed {
    logic act;  // row lies inside the rows in use
    logic hit;  // row equals the requested row
  } row_sel_t;

  // Result flags travelling along the chain of cells.
  typedef struct packed {
    cell_t rd;
    logic  mv;
  } chain_res_t;

endpackage

@@ hw/rtl/tah_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traffic automaton channel interfaces
// Valid/ready channels for commands, results and configuration writes.
// ----------------------------------------------------------------------------

// Command channel.
interface tah_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [tah_pkg::CmdW-1:0]      command;
  logic [tah_pkg::RowFieldW-1:0] row;
  logic [tah_pkg::ColFieldW-1:0] col;
  logic [tah_pkg::CellW-1:0]     cell_value;
  logic                         move_color;

  modport source (output valid, command, row, col, cell_value, move_color, input ready);
  modport sink   (input valid, command, row, col, cell_value, move_color, output ready);
endinterface

// Result channel.
interface tah_res_if;
  logic                     valid;
  logic                     ready;
  logic [tah_pkg::CellW-1:0] read_value;
  logic                     any_moved;

  modport source (output valid, read_value, any_moved, input ready);
  modport sink   (input valid, read_value, any_moved, output ready);
endinterface

// Configuration write channel.
interface tah_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tah_pkg::CfgIdxW-1:0]  index;
  logic [tah_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/tah_row_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traffic automaton row cell
// Holds one grid row as a rotating shift line and, during a command sweep,
// updates its head column each cycle, using neighbour row heads for blue moves.
// ----------------------------------------------------------------------------
module tah_row_cell #(
  parameter int MAX_COLS = tah_pkg::DefMaxCols
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tah_pkg::row_ctrl_t  ctrl_i,
  input  tah_pkg::row_sel_t   sel_i,
  input  tah_pkg::cell_t      up_i,
  input  tah_pkg::cell_t      down_i,
  input  tah_pkg::chain_res_t res_prev_i,
  output tah_pkg::cell_t      head_o,
  output tah_pkg::chain_res_t res_o
);

  tah_pkg::cell_t      row_q [MAX_COLS];
  tah_pkg::cell_t      row_d [MAX_COLS];
  tah_pkg::cell_t      prev_q, s0_q, s1_q, sl_q;
  tah_pkg::cell_t      orig, nxt, prv, kind, src, dst, new_val, rd_cap;
  logic                active, moved;
  tah_pkg::chain_res_t res_q, res_d;

  // The head always holds the original content of the column in work.
  assign orig   = row_q[0];
  assign head_o = orig;

  // Right and left neighbours in the snapshot; the wrap columns come from captures.
  assign nxt = ctrl_i.col_last ? s0_q : (ctrl_i.col0_pass ? s1_q : row_q[1]);
  assign prv = ctrl_i.col0_pass ? sl_q : prev_q;

  assign kind = ctrl_i.blue ? tah_pkg::CellBlue : tah_pkg::CellRed;
  assign src  = ctrl_i.blue ? up_i : prv;
  assign dst  = ctrl_i.blue ? down_i : nxt;

  assign active = sel_i.act & ctrl_i.col_in & ctrl_i.proc;

  // Cell update: a car leaves if its target was empty, a car arrives if this
  // cell was empty and the source held a car of the moving colour.
  always_comb begin
    new_val = orig;
    moved   = 1'b0;
    rd_cap  = tah_pkg::CellEmpty;
    if (active) begin
      if (ctrl_i.step_en) begin
        if (orig == kind && dst == tah_pkg::CellEmpty) begin
          new_val = tah_pkg::CellEmpty;
          moved   = 1'b1;
        end else if (orig == tah_pkg::CellEmpty && src == kind) begin
          new_val = kind;
        end
      end
      if (ctrl_i.load_en && sel_i.hit && ctrl_i.col_hit) begin
        new_val = ctrl_i.load_val;
      end
      if (ctrl_i.read_en && sel_i.hit && ctrl_i.col_hit) begin
        rd_cap = orig;
      end
    end
  end

  // Row rotation: the processed head goes to the tail, or stays in place on
  // the final pass over column 0.
  always_comb begin
    row_d = row_q;
    if (ctrl_i.shift) begin
      for (int i = 0; i < MAX_COLS - 1; i++) begin
        row_d[i] = row_q[i+1];
      end
      row_d[MAX_COLS-1] = new_val;
    end else if (ctrl_i.proc) begin
      row_d[0] = new_val;
    end
  end

  // Result flags are ORed in from the previous cell and moved on each cycle.
  always_comb begin
    if (ctrl_i.clear) begin
      res_d = '0;
    end else begin
      res_d.rd = res_q.rd | res_prev_i.rd | rd_cap;
      res_d.mv = res_q.mv | res_prev_i.mv | moved;
    end
  end

  assign res_o = res_q;

  // Grid row and result flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_COLS; i++) begin
        row_q[i] <= tah_pkg::CellEmpty;
      end
      res_q <= '0;
    end else begin
      row_q <= row_d;
      res_q <= res_d;
    end
  end

  // Snapshot captures for the left neighbour and the wrap columns.
  always_ff @(posedge clk_i) begin
    prev_q <= orig;
    if (ctrl_i.cap_s0) begin
      s0_q <= orig;
    end
    if (ctrl_i.cap_s1) begin
      s1_q <= orig;
    end
    if (ctrl_i.col_last) begin
      sl_q <= orig;
    end
  end

endmodule

@@ hw/rtl/traffic_automaton_half_step_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traffic automaton half step, top level
// Toroidal two-colour traffic grid held in a chain of row cells. Every
// command sweeps the rows one column per cycle; results travel down the chain.
//
//   Channel   Dir   Transfer carries
//   cfg_i     in    index, data            (size registers, always ready)
//   cmd_i     in    command, row, col, cell_value, move_color
//   res_o     out   read_value, any_moved  (one per command)
//
// A command sweeps every row one column at a time, with column 0 revisited
// last; the result flags then ripple to the end of the row chain and are
// loaded into the output register, and the next command transfers once the
// sequencer is idle again.
// Reset clears the grid at once. A new command is taken while the last
// result still waits in the output register; a command finishing before that
// result is taken waits in its final state.
// ----------------------------------------------------------------------------
module traffic_automaton_half_step_top #(
  parameter int MAX_ROWS = tah_pkg::DefMaxRows,
  parameter int MAX_COLS = tah_pkg::DefMaxCols
) (
  input logic       clk_i,
  input logic       rst_ni,
  tah_cfg_if.sink   cfg_i,
  tah_cmd_if.sink   cmd_i,
  tah_res_if.source res_o
);

  localparam int RowW    = $clog2(MAX_ROWS + 1);
  localparam int ColW    = $clog2(MAX_COLS + 1);
  localparam int RowIdxW = $clog2(MAX_ROWS);
  localparam int RCmpW   = (RowW > tah_pkg::CfgDataW) ? RowW : tah_pkg::CfgDataW;
  localparam int CCmpW   = (ColW > tah_pkg::CfgDataW) ? ColW : tah_pkg::CfgDataW;
  localparam int CntW    = (ColW > RowIdxW) ? ColW : RowIdxW;

  typedef enum logic [1:0] {
    StIdle,
    StSweep,
    StDrain,
    StDone
  } state_e;

  state_e                         state_q;
  logic [CntW-1:0]                cnt_q;
  logic                           res_valid_q;
  tah_pkg::cell_t                 res_rd_q;
  logic                           res_mv_q;
  logic [tah_pkg::CmdW-1:0]       cmd_q;
  logic [tah_pkg::RowFieldW-1:0]  req_row_q;
  logic [tah_pkg::ColFieldW-1:0]  req_col_q;
  tah_pkg::cell_t                 val_q;
  logic                           blue_q;
  logic [tah_pkg::CfgDataW-1:0]   rows_cfg_q, cols_cfg_q;
  logic [RCmpW-1:0]               rows_raw;
  logic [CCmpW-1:0]               cols_raw;
  logic [RowW-1:0]                nr, nr_m1;
  logic [ColW-1:0]                nc, pcol;
  logic                           cmd_xfer, sweep, last_sweep;
  tah_pkg::row_ctrl_t             ctrl;
  tah_pkg::row_sel_t              sel   [MAX_ROWS];
  tah_pkg::cell_t                 head  [MAX_ROWS];
  tah_pkg::cell_t                 up    [MAX_ROWS];
  tah_pkg::cell_t                 down  [MAX_ROWS];
  tah_pkg::chain_res_t            chain [MAX_ROWS];
  tah_pkg::chain_res_t            chain_in [MAX_ROWS];
  tah_pkg::cell_t                 last_head;

  // Size registers; writes to other indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= tah_pkg::SizeReset;
      cols_cfg_q <= tah_pkg::SizeReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        tah_pkg::RegRowsInUse: rows_cfg_q <= cfg_i.data;
        tah_pkg::RegColsInUse: cols_cfg_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Sizes in use, clamped to the range the grid supports.
  assign rows_raw = RCmpW'(rows_cfg_q);
  assign cols_raw = CCmpW'(cols_cfg_q);

  always_comb begin
    if (rows_raw < RCmpW'(tah_pkg::SizeMin)) begin
      nr = RowW'(tah_pkg::SizeMin);
    end else if (rows_raw > RCmpW'(MAX_ROWS)) begin
      nr = RowW'(MAX_ROWS);
    end else begin
      nr = rows_raw[RowW-1:0];
    end
    if (cols_raw < CCmpW'(tah_pkg::SizeMin)) begin
      nc = ColW'(tah_pkg::SizeMin);
    end else if (cols_raw > CCmpW'(MAX_COLS)) begin
      nc = ColW'(MAX_COLS);
    end else begin
      nc = cols_raw[ColW-1:0];
    end
  end

  assign nr_m1 = nr - RowW'(1);

  // Sequencer: sweep, drain and result hand-off.
  assign cmd_xfer    = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = (state_q == StIdle);

  assign res_o.valid      = res_valid_q;
  assign res_o.read_value = res_rd_q;
  assign res_o.any_moved  = res_mv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      res_rd_q    <= tah_pkg::CellEmpty;
      res_mv_q    <= 1'b0;
    end else begin
      // A result transfer frees the output register unless the next result
      // is loaded into it in the same cycle.
      if (res_o.valid && res_o.ready && (state_q != StDone)) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (cmd_xfer) begin
            state_q <= StSweep;
            cnt_q   <= '0;
          end
        end
        StSweep: begin
          if (last_sweep) begin
            state_q <= StDrain;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        StDrain: begin
          if (cnt_q == CntW'(MAX_ROWS - 2)) begin
            state_q <= StDone;
          end else begin
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        StDone: begin
          if (!res_valid_q || res_o.ready) begin
            res_valid_q <= 1'b1;
            res_rd_q    <= chain[MAX_ROWS-1].rd;
            res_mv_q    <= chain[MAX_ROWS-1].mv;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Command fields held for the whole sweep.
  always_ff @(posedge clk_i) begin
    if (cmd_xfer) begin
      cmd_q     <= cmd_i.command;
      req_row_q <= cmd_i.row;
      req_col_q <= cmd_i.col;
      val_q     <= cmd_i.cell_value;
      blue_q    <= cmd_i.move_color;
    end
  end

  // Column control: the first cycle only rotates column 0 away, the last
  // cycle processes column 0 in place.
  assign sweep      = (state_q == StSweep);
  assign last_sweep = (cnt_q == CntW'(MAX_COLS));
  assign pcol       = last_sweep ? '0 : cnt_q[ColW-1:0];

  always_comb begin
    ctrl.clear     = cmd_xfer;
    ctrl.shift     = sweep & ~last_sweep;
    ctrl.proc      = sweep & (cnt_q != '0);
    ctrl.step_en   = (cmd_q == tah_pkg::CmdStep);
    ctrl.blue      = blue_q;
    ctrl.load_en   = (cmd_q == tah_pkg::CmdLoad) && (val_q != tah_pkg::CellBad);
    ctrl.load_val  = val_q;
    ctrl.read_en   = (cmd_q == tah_pkg::CmdRead);
    ctrl.col_in    = (pcol < nc);
    ctrl.col_hit   = (CCmpW'(pcol) == CCmpW'(req_col_q));
    ctrl.col_last  = sweep & ~last_sweep & (pcol == nc - ColW'(1));
    ctrl.col0_pass = sweep & last_sweep;
    ctrl.cap_s0    = sweep & (cnt_q == '0);
    ctrl.cap_s1    = sweep & (cnt_q == CntW'(1));
  end

  // Head of the last row in use, the upper neighbour of row 0.
  assign last_head = head[nr_m1[RowIdxW-1:0]];

  // Chain of row cells with torus wiring between neighbours.
  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_row
    localparam int Nx = (g + 1) % MAX_ROWS;

    assign sel[g].act = (RowW'(g) < nr);
    assign sel[g].hit = (RCmpW'(req_row_q) == RCmpW'(g));

    assign down[g] = (RowW'(g) == nr_m1) ? head[0] : head[Nx];

    if (g == 0) begin : g_first
      assign up[g]       = last_head;
      assign chain_in[g] = '0;
    end else begin : g_rest
      assign up[g]       = head[g-1];
      assign chain_in[g] = chain[g-1];
    end

    tah_row_cell #(
      .MAX_COLS (MAX_COLS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .sel_i      (sel[g]),
      .up_i       (up[g]),
      .down_i     (down[g]),
      .res_prev_i (chain_in[g]),
      .head_o     (head[g]),
      .res_o      (chain[g])
    );
  end

endmodule
